>>> src/npuoce_pkg.sv
package npuoce_pkg;

  // Field and datapath widths
  localparam int CYC_W  = 48;
  localparam int LCL_W  = 33;
  localparam int SLOT_W = 24;
  localparam int DIV_W  = 33;
  localparam int DVS_W  = 13;
  localparam int SUM_W  = 50;

  localparam int NUM_LANES_DEF = 8;

  localparam logic [CYC_W-1:0] CYCLE_MAX = {CYC_W{1'b1}};

  // Operation modes
  localparam logic [2:0] MODE_SYS   = 3'd0;
  localparam logic [2:0] MODE_FETCH = 3'd1;
  localparam logic [2:0] MODE_LOCAL = 3'd2;
  localparam logic [2:0] MODE_FENCE = 3'd3;
  localparam logic [2:0] MODE_NPU   = 3'd4;

  // NPU instruction classes
  localparam logic [2:0] CLS_FRONT  = 3'd0;
  localparam logic [2:0] CLS_MMOVE  = 3'd1;
  localparam logic [2:0] CLS_MCLEAR = 3'd2;
  localparam logic [2:0] CLS_MMUL   = 3'd3;
  localparam logic [2:0] CLS_VEC    = 3'd4;
  localparam logic [2:0] CLS_VDIV   = 3'd5;
  localparam logic [2:0] CLS_VSQRT  = 3'd6;
  localparam logic [2:0] CLS_VRED   = 3'd7;

  // Busy units
  localparam logic [2:0] UNIT_MEM    = 3'd0;
  localparam logic [2:0] UNIT_FRONT  = 3'd1;
  localparam logic [2:0] UNIT_LOCAL  = 3'd2;
  localparam logic [2:0] UNIT_SYNC   = 3'd3;
  localparam logic [2:0] UNIT_MATRIX = 3'd4;
  localparam logic [2:0] UNIT_VECTOR = 3'd5;

  // Register indexes
  localparam logic [2:0] REG_FE_LAT   = 3'd0;
  localparam logic [2:0] REG_VS_LAT   = 3'd1;
  localparam logic [2:0] REG_DIV_LAT  = 3'd2;
  localparam logic [2:0] REG_SQRT_LAT = 3'd3;
  localparam logic [2:0] REG_ROWS     = 3'd4;
  localparam logic [2:0] REG_COLS     = 3'd5;
  localparam logic [2:0] REG_PORT     = 3'd6;
  localparam logic [2:0] REG_DMA_LAT  = 3'd7;

  // Register reset values
  localparam logic [15:0]      RST_FE_LAT   = 16'd1;
  localparam logic [15:0]      RST_VS_LAT   = 16'd4;
  localparam logic [15:0]      RST_DIV_LAT  = 16'd16;
  localparam logic [15:0]      RST_SQRT_LAT = 16'd16;
  localparam logic [DVS_W-1:0] RST_ROWS     = 13'd16;
  localparam logic [DVS_W-1:0] RST_COLS     = 13'd16;
  localparam logic [DVS_W-1:0] RST_PORT     = 13'd64;
  localparam logic [15:0]      RST_DMA_LAT  = 16'd32;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  op_class;
    logic [31:0] access_bytes;
    logic [31:0] read_bytes;
    logic [31:0] write_bytes;
    logic [15:0] dim_m;
    logic [15:0] dim_n;
    logic [15:0] dim_k;
    logic [15:0] lane_count;
    logic [15:0] active_count;
  } oce_req_t;

  typedef struct packed {
    logic [CYC_W-1:0]  cycle_estimate;
    logic [15:0]       active_out;
    logic [SLOT_W-1:0] slot_count;
    logic [CYC_W-1:0]  mac_count;
    logic [LCL_W-1:0]  lcl_bytes;
    logic [2:0]        unit;
  } oce_res_t;

  // Latency registers used after the dividers
  typedef struct packed {
    logic [15:0] fe_lat;
    logic [15:0] vs_lat;
    logic [15:0] div_lat;
    logic [15:0] sqrt_lat;
    logic [15:0] dma_lat;
  } oce_cfg_t;

  // Request fields that travel beside the dividers
  typedef struct packed {
    logic [2:0]       mode;
    logic [2:0]       op_class;
    logic [15:0]      dim_m;
    logic [15:0]      dim_n;
    logic [15:0]      dim_k;
    logic [15:0]      active_count;
    logic [15:0]      lane_grp;
    logic [31:0]      mn;
    logic [LCL_W-1:0] lcl;
  } oce_side_t;

  // Divider results: quotient and remainder-nonzero flag
  typedef struct packed {
    logic [LCL_W-1:0] port_q;
    logic             port_r;
    logic [15:0]      rows_q;
    logic             rows_r;
    logic [15:0]      cols_q;
    logic             cols_r;
    logic [31:0]      mn_q;
    logic             mn_r;
  } oce_quo_t;

endpackage

>>> src/npuoce_div.sv
module npuoce_div import npuoce_pkg::*; #(
  parameter int DW = DIV_W,
  parameter int VW = DVS_W
) (
  input  logic          clk_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quot_o,
  output logic          rem_nz_o
);

  logic [VW-1:0] rem_q [DW];
  logic [DW-1:0] dq_q  [DW];

  // Restoring division, one quotient bit per stage
  for (genvar s = 0; s < DW; s++) begin : g_stage
    logic [VW-1:0] rem_in;
    logic [DW-1:0] dq_in;
    logic [VW:0]   trial;
    logic          ge;
    logic [VW-1:0] rem_d;
    logic [DW-1:0] dq_d;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign dq_in  = dq_q[s-1];
    end

    assign trial = {rem_in, dq_in[DW-1]};
    assign ge    = trial >= {1'b0, divisor_i};
    assign rem_d = ge ? VW'(trial - {1'b0, divisor_i}) : VW'(trial);
    assign dq_d  = {dq_in[DW-2:0], ge};

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      dq_q[s]  <= dq_d;
    end
  end

  assign quot_o   = dq_q[DW-1];
  assign rem_nz_o = rem_q[DW-1] != '0;

endmodule

>>> src/npuoce_calc.sv
module npuoce_calc import npuoce_pkg::*; #(
  parameter int NUM_LANES = NUM_LANES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  input  oce_side_t side_i,
  input  oce_quo_t  quo_i,
  input  oce_cfg_t  cfg_i,
  output logic      done_o,
  output oce_res_t  res_o
);

  localparam logic [SLOT_W-1:0] VL = SLOT_W'(NUM_LANES);

  // Stage 1: round quotients up, start MAC product
  logic             v1_q;
  oce_side_t        s1_q;
  logic [LCL_W-1:0] pc1_q, pc1_d;
  logic [15:0]      tm1_q, tm1_d, tn1_q, tn1_d, g1_q, g1_d;
  logic [31:0]      cg1_q, cg1_d;
  logic [CYC_W-1:0] mac1_q, mac1_d;

  always_comb begin
    pc1_d  = quo_i.port_q + LCL_W'(quo_i.port_r);
    tm1_d  = quo_i.rows_q + 16'(quo_i.rows_r);
    tn1_d  = quo_i.cols_q + 16'(quo_i.cols_r);
    cg1_d  = quo_i.mn_q + 32'(quo_i.mn_r);
    g1_d   = side_i.lane_grp;
    mac1_d = {16'd0, side_i.mn} * {32'd0, side_i.dim_k};
  end

  always_ff @(posedge clk_i) begin
    s1_q   <= side_i;
    pc1_q  <= pc1_d;
    tm1_q  <= tm1_d;
    tn1_q  <= tn1_d;
    cg1_q  <= cg1_d;
    g1_q   <= g1_d;
    mac1_q <= mac1_d;
  end

  // Stage 2: tile and lane products, base cycles
  logic              v2_q;
  oce_side_t         s2_q;
  logic [LCL_W-1:0]  pc2_q;
  logic [31:0]       cg2_q, p1_q, p1_d, p2_q, p2_d, p3_q, p3_d, gl_q, gl_d;
  logic [CYC_W-1:0]  mac2_q;
  logic [SLOT_W-1:0] slot2_q, slot2_d;
  logic [SUM_W-1:0]  base2_q, base2_d;
  logic [15:0]       lat;

  always_comb begin
    case (s1_q.op_class)
      CLS_VDIV:  lat = cfg_i.div_lat;
      CLS_VSQRT: lat = cfg_i.sqrt_lat;
      default:   lat = 16'd1;
    endcase
    p1_d    = {16'd0, tn1_q} * {16'd0, s1_q.dim_m};
    p2_d    = {16'd0, tm1_q} * {16'd0, s1_q.dim_n};
    p3_d    = {16'd0, tm1_q} * {16'd0, tn1_q};
    gl_d    = {16'd0, g1_q} * {16'd0, lat};
    slot2_d = {8'd0, g1_q} * VL;
    base2_d = SUM_W'(cfg_i.vs_lat) + SUM_W'(pc1_q);
  end

  always_ff @(posedge clk_i) begin
    s2_q    <= s1_q;
    pc2_q   <= pc1_q;
    cg2_q   <= cg1_q;
    mac2_q  <= mac1_q;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    p3_q    <= p3_d;
    gl_q    <= gl_d;
    slot2_q <= slot2_d;
    base2_q <= base2_d;
  end

  // Stage 3: per-class cycle sums
  logic              v3_q;
  oce_side_t         s3_q;
  logic [LCL_W-1:0]  pc3_q;
  logic [CYC_W-1:0]  mac3_q, p4_q, p4_d;
  logic [SLOT_W-1:0] slot3_q;
  logic [SUM_W-1:0]  base3_q, part3_q, part3_d, vec3_q, vec3_d, clr3_q, clr3_d;
  logic [15:0]       km1;
  logic [15:0]       red_add;

  always_comb begin
    km1     = (s2_q.dim_k != 16'd0) ? s2_q.dim_k - 16'd1 : 16'd0;
    red_add = (s2_q.op_class == CLS_VRED) ? s2_q.active_count : 16'd0;
    p4_d    = {16'd0, p3_q} * {32'd0, km1};
    part3_d = base2_q + SUM_W'(p1_q) + SUM_W'(p2_q);
    vec3_d  = base2_q + SUM_W'(gl_q) + SUM_W'(red_add);
    clr3_d  = base2_q + SUM_W'(cg2_q);
  end

  always_ff @(posedge clk_i) begin
    s3_q    <= s2_q;
    pc3_q   <= pc2_q;
    mac3_q  <= mac2_q;
    slot3_q <= slot2_q;
    p4_q    <= p4_d;
    base3_q <= base2_q;
    part3_q <= part3_d;
    vec3_q  <= vec3_d;
    clr3_q  <= clr3_d;
  end

  // Stage 4: select by mode and class, saturate
  oce_res_t         res_q, res_d;
  logic [SUM_W-1:0] cyc;

  always_comb begin
    res_d = '0;
    cyc   = SUM_W'(1);
    res_d.unit = UNIT_SYNC;
    unique case (s3_q.mode)
      MODE_SYS: begin
        cyc        = SUM_W'(cfg_i.dma_lat);
        res_d.unit = UNIT_MEM;
      end
      MODE_FETCH: begin
        cyc        = SUM_W'(cfg_i.fe_lat);
        res_d.unit = UNIT_FRONT;
      end
      MODE_LOCAL: begin
        cyc             = (pc3_q == '0) ? SUM_W'(1) : SUM_W'(pc3_q);
        res_d.lcl_bytes = s3_q.lcl;
        res_d.unit      = UNIT_LOCAL;
      end
      MODE_NPU: begin
        if (s3_q.op_class == CLS_FRONT) begin
          cyc        = SUM_W'(cfg_i.fe_lat);
          res_d.unit = UNIT_FRONT;
        end else begin
          res_d.lcl_bytes  = s3_q.lcl;
          res_d.active_out = s3_q.active_count;
          case (s3_q.op_class)
            CLS_MMUL: begin
              cyc = (s3_q.dim_k != 16'd0) ? part3_q + SUM_W'(p4_q) : base3_q;
              res_d.mac_count = mac3_q;
              res_d.unit      = UNIT_MATRIX;
            end
            CLS_MMOVE: begin
              cyc        = base3_q;
              res_d.unit = UNIT_MATRIX;
            end
            CLS_MCLEAR: begin
              cyc        = clr3_q;
              res_d.unit = UNIT_MATRIX;
            end
            default: begin
              cyc              = vec3_q;
              res_d.slot_count = slot3_q;
              res_d.unit       = UNIT_VECTOR;
            end
          endcase
        end
      end
      default: begin
        cyc        = SUM_W'(1);
        res_d.unit = UNIT_SYNC;
      end
    endcase
    res_d.cycle_estimate = (cyc > SUM_W'(CYCLE_MAX)) ? CYCLE_MAX : CYC_W'(cyc);
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Advance valid bits
  logic v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign done_o = v4_q;
  assign res_o  = res_q;

endmodule

>>> src/npu_operation_cycle_estimator_top.sv
// Operation cycle estimator: one request in, one result out.
// Path: a request passes the input and operand stages, a 33-stage bit-per-stage divider
// and four arithmetic stages before the result strobe is high.
// Throughput: one request per cycle; busy_o stays low and the receiver cannot stall.
// Reset: rst_ni clears the valid pipeline and loads register reset values.
module npu_operation_cycle_estimator_top import npuoce_pkg::*; #(
  parameter int NUM_LANES = NUM_LANES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  oce_req_t    req_i,
  output logic        done_o,
  output oce_res_t    res_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  // Lane group rounding: ceil(x / lanes) as a reciprocal multiply on x + lanes - 1
  localparam int          LG_SH   = 17 + $clog2(NUM_LANES);
  localparam logic [18:0] LG_RCP  = 19'(((64'd1 << LG_SH) + 64'(NUM_LANES) - 64'd1)
                                        / 64'(NUM_LANES));
  localparam logic [16:0] LG_BIAS = 17'(NUM_LANES - 1);

  // Configuration registers
  logic [15:0]      fe_lat_q, vs_lat_q, div_lat_q, sqrt_lat_q, dma_lat_q;
  logic [DVS_W-1:0] rows_q, cols_q, port_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_lat_q   <= RST_FE_LAT;
      vs_lat_q   <= RST_VS_LAT;
      div_lat_q  <= RST_DIV_LAT;
      sqrt_lat_q <= RST_SQRT_LAT;
      rows_q     <= RST_ROWS;
      cols_q     <= RST_COLS;
      port_q     <= RST_PORT;
      dma_lat_q  <= RST_DMA_LAT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FE_LAT:   fe_lat_q   <= cfg_wdata_i;
        REG_VS_LAT:   vs_lat_q   <= cfg_wdata_i;
        REG_DIV_LAT:  div_lat_q  <= cfg_wdata_i;
        REG_SQRT_LAT: sqrt_lat_q <= cfg_wdata_i;
        REG_ROWS:     rows_q     <= cfg_wdata_i[DVS_W-1:0];
        REG_COLS:     cols_q     <= cfg_wdata_i[DVS_W-1:0];
        REG_PORT:     port_q     <= cfg_wdata_i[DVS_W-1:0];
        REG_DMA_LAT:  dma_lat_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Use a zero divisor as one
  logic [DVS_W-1:0] rows_nz, cols_nz, port_nz;
  oce_cfg_t         cfg;

  assign rows_nz = (rows_q == '0) ? DVS_W'(1) : rows_q;
  assign cols_nz = (cols_q == '0) ? DVS_W'(1) : cols_q;
  assign port_nz = (port_q == '0) ? DVS_W'(1) : port_q;

  assign cfg.fe_lat   = fe_lat_q;
  assign cfg.vs_lat   = vs_lat_q;
  assign cfg.div_lat  = div_lat_q;
  assign cfg.sqrt_lat = sqrt_lat_q;
  assign cfg.dma_lat  = dma_lat_q;

  assign busy_o = 1'b0;

  // Stage A: capture request
  logic     va_q;
  oce_req_t ra_q;

  always_ff @(posedge clk_i) begin
    ra_q <= req_i;
  end

  // Stage B: local byte total, M*N product and lane groups
  logic        vb_q;
  oce_side_t   sb_q, sb_d;
  logic [16:0] lanes_rnd;
  logic [47:0] lanes_prod;

  always_comb begin
    lanes_rnd         = {1'b0, ra_q.lane_count} + LG_BIAS;
    lanes_prod        = {31'd0, lanes_rnd} * {29'd0, LG_RCP};
    sb_d.mode         = ra_q.mode;
    sb_d.op_class     = ra_q.op_class;
    sb_d.dim_m        = ra_q.dim_m;
    sb_d.dim_n        = ra_q.dim_n;
    sb_d.dim_k        = ra_q.dim_k;
    sb_d.active_count = ra_q.active_count;
    sb_d.lane_grp     = lanes_prod[LG_SH +: 16];
    sb_d.mn           = {16'd0, ra_q.dim_m} * {16'd0, ra_q.dim_n};
    sb_d.lcl          = (ra_q.mode == MODE_LOCAL) ? {1'b0, ra_q.access_bytes}
                        : {1'b0, ra_q.read_bytes} + {1'b0, ra_q.write_bytes};
  end

  always_ff @(posedge clk_i) begin
    sb_q <= sb_d;
  end

  // Ceiling dividers
  logic [DIV_W-1:0] q_port, q_rows, q_cols, q_mn;
  logic             r_port, r_rows, r_cols, r_mn;

  npuoce_div #(.DW(DIV_W), .VW(DVS_W)) u_div_port (
    .clk_i      (clk_i),
    .dividend_i (sb_q.lcl),
    .divisor_i  (port_nz),
    .quot_o     (q_port),
    .rem_nz_o   (r_port)
  );

  npuoce_div #(.DW(DIV_W), .VW(DVS_W)) u_div_rows (
    .clk_i      (clk_i),
    .dividend_i (DIV_W'(sb_q.dim_m)),
    .divisor_i  (rows_nz),
    .quot_o     (q_rows),
    .rem_nz_o   (r_rows)
  );

  npuoce_div #(.DW(DIV_W), .VW(DVS_W)) u_div_cols (
    .clk_i      (clk_i),
    .dividend_i (DIV_W'(sb_q.dim_n)),
    .divisor_i  (cols_nz),
    .quot_o     (q_cols),
    .rem_nz_o   (r_cols)
  );

  npuoce_div #(.DW(DIV_W), .VW(DVS_W)) u_div_mn (
    .clk_i      (clk_i),
    .dividend_i (DIV_W'(sb_q.mn)),
    .divisor_i  (cols_nz),
    .quot_o     (q_mn),
    .rem_nz_o   (r_mn)
  );

  // Carry request fields beside the dividers
  oce_side_t sd_q [DIV_W];
  logic [DIV_W-1:0] vd_q;

  always_ff @(posedge clk_i) begin
    sd_q[0] <= sb_q;
    for (int i = 1; i < DIV_W; i++) begin
      sd_q[i] <= sd_q[i-1];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vd_q <= '0;
    end else begin
      va_q <= start_i && !busy_o;
      vb_q <= va_q;
      vd_q <= {vd_q[DIV_W-2:0], vb_q};
    end
  end

  oce_quo_t quo;

  assign quo.port_q = q_port[LCL_W-1:0];
  assign quo.port_r = r_port;
  assign quo.rows_q = q_rows[15:0];
  assign quo.rows_r = r_rows;
  assign quo.cols_q = q_cols[15:0];
  assign quo.cols_r = r_cols;
  assign quo.mn_q   = q_mn[31:0];
  assign quo.mn_r   = r_mn;

  npuoce_calc #(.NUM_LANES(NUM_LANES)) u_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vd_q[DIV_W-1]),
    .side_i (sd_q[DIV_W-1]),
    .quo_i  (quo),
    .cfg_i  (cfg),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule
